### hw/rtl/iiee_pkg.sv
// ----------------------------------------------------------------------------
// iiee_pkg
// Shared types and constants for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iiee_pkg;

  localparam int VW = 32;

  // Character codes
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_REM   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Token kinds
  localparam logic [2:0] TK_NUM   = 3'd0;
  localparam logic [2:0] TK_PLUS  = 3'd1;
  localparam logic [2:0] TK_MINUS = 3'd2;
  localparam logic [2:0] TK_MUL   = 3'd3;
  localparam logic [2:0] TK_DIV   = 3'd4;
  localparam logic [2:0] TK_REM   = 3'd5;
  localparam logic [2:0] TK_NONE  = 3'd6;

  // Multiplicative ops
  localparam logic [1:0] MOP_NONE = 2'd0;
  localparam logic [1:0] MOP_MUL  = 2'd1;
  localparam logic [1:0] MOP_DIV  = 2'd2;
  localparam logic [1:0] MOP_REM  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INV   = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One token handed from front to back; a token may carry a number, an
  // operator, and the end-of-line mark together.
  typedef struct packed {
    logic          has_num;
    logic [VW-1:0] num;
    logic [1:0]    num_err;   // error found while forming the number
    logic [2:0]    op;        // TK_NONE when no operator
    logic          eol;
  } tok_t;

  // Merge a new error into an error code
  function automatic logic [1:0] err_merge(input logic [1:0] cur, input logic [1:0] code);
    logic [1:0] r;
    r = cur;
    if (code == ST_INV) r = ST_INV;
    else if (cur == ST_OK) r = code;
    return r;
  endfunction

endpackage

### hw/rtl/infix_integer_expression_evaluator.sv
// Throughput: one character per cycle while the 4-entry token queue has room;
//   the back end takes the next token only once it has retired the last one,
//   and a divide or remainder first runs through the shift divider.
// Reset: synchronous active-low rst_n clears line state and previous answer.
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Streams equation characters and returns the value or an error status.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [33:32] status, zero fill
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]    prev_r;
  logic           fq_valid, fq_ready, qb_valid, qb_ready, bk_ready, held_r;
  iiee_pkg::tok_t fq_tok, qb_tok;
  logic [33:0]    bk_data;

  // Hold previous answer register
  always_ff @(posedge clk) begin
    if (!rst_n) prev_r <= '0;
    else if (cfg_we) prev_r <= cfg_wdata;
  end

  iiee_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_char(in_tdata), .in_eol(in_tlast),
    .prev_ans(prev_r), .tok_valid(fq_valid), .tok_ready(fq_ready), .tok(fq_tok)
  );

  iiee_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_tok),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_tok)
  );

  // Pop the head only once the back end has fully retired it
  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= 1'b0;
    else if (qb_valid && bk_ready && !held_r) held_r <= 1'b1;
    else if (bk_ready && held_r) held_r <= 1'b0;
  end
  assign qb_ready = held_r && bk_ready;

  iiee_back u_back (
    .clk, .rst_n, .tok_valid(qb_valid && !held_r), .tok_ready(bk_ready), .tok(qb_tok),
    .out_tvalid, .out_tready, .out_tdata(bk_data)
  );

  assign out_tdata = {6'b0, bk_data};

  // Result value is zero when status is not ok
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != iiee_pkg::ST_OK |-> out_tdata[31:0] == '0)
    else $error("error result with nonzero value");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == '0)
    else $error("pad bits set");

endmodule

### hw/rtl/iiee_front.sv
// ----------------------------------------------------------------------------
// iiee_front
// Scans characters, forms numbers, emits tokens into the queue.
// ----------------------------------------------------------------------------
module iiee_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_char,
  input  logic                     in_eol,
  input  logic [iiee_pkg::VW-1:0]  prev_ans,
  output logic                     tok_valid,
  input  logic                     tok_ready,
  output iiee_pkg::tok_t           tok
);

  logic [iiee_pkg::VW-1:0] acc_r, acc_nxt;
  logic                    in_num_r, in_num_nxt;
  logic [1:0]              nerr_r, nerr_nxt;

  logic                    is_digit;
  logic [3:0]              dig;
  logic [iiee_pkg::VW+3:0] acc_x10;
  logic [iiee_pkg::VW+3:0] acc_new;
  logic [2:0]              opk;
  logic                    emit;

  assign in_tready = tok_ready;
  assign is_digit  = (in_char >= iiee_pkg::CH_ZERO) && (in_char <= iiee_pkg::CH_NINE);
  assign dig       = 4'(in_char - iiee_pkg::CH_ZERO);
  assign acc_x10   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1);
  assign acc_new   = acc_x10 + {{iiee_pkg::VW{1'b0}}, dig};

  // Classify operator characters
  always_comb begin
    unique case (in_char)
      iiee_pkg::CH_PLUS:  opk = iiee_pkg::TK_PLUS;
      iiee_pkg::CH_MINUS: opk = iiee_pkg::TK_MINUS;
      iiee_pkg::CH_MUL:   opk = iiee_pkg::TK_MUL;
      iiee_pkg::CH_DIV:   opk = iiee_pkg::TK_DIV;
      iiee_pkg::CH_REM:   opk = iiee_pkg::TK_REM;
      default:            opk = iiee_pkg::TK_NONE;
    endcase
  end

  // Build token and next number state
  always_comb begin
    acc_nxt    = acc_r;
    in_num_nxt = in_num_r;
    nerr_nxt   = nerr_r;
    tok        = '0;
    tok.op     = iiee_pkg::TK_NONE;
    tok.eol    = in_eol;
    emit       = in_eol;
    if (is_digit) begin
      in_num_nxt = 1'b1;
      if (acc_new > {4'b0, iiee_pkg::VMAX}) begin
        acc_nxt  = iiee_pkg::VMAX;
        nerr_nxt = iiee_pkg::ST_OVF;
      end else begin
        acc_nxt = acc_new[iiee_pkg::VW-1:0];
      end
      if (in_eol) begin
        tok.has_num = 1'b1;
        tok.num     = acc_nxt;
        tok.num_err = nerr_nxt;
      end
    end else begin
      // Close any pending number first
      if (in_num_r) begin
        tok.has_num = 1'b1;
        tok.num     = acc_r;
        tok.num_err = nerr_r;
        emit        = 1'b1;
      end
      if (in_char == iiee_pkg::CH_A) begin
        emit = 1'b1;
        // Number plus answer in one character is two numbers; when both occur,
        // send the pending number with an invalid mark in place of the answer.
        if (in_num_r) tok.num_err = iiee_pkg::ST_INV;
        else begin
          tok.has_num = 1'b1;
          tok.num     = prev_ans[iiee_pkg::VW-1] ? '0 : prev_ans;
          tok.num_err = prev_ans[iiee_pkg::VW-1] ? iiee_pkg::ST_INV : iiee_pkg::ST_OK;
        end
      end else if (opk != iiee_pkg::TK_NONE) begin
        tok.op = opk;
        emit   = 1'b1;
      end
    end
    if (in_eol || !is_digit) begin
      if (in_eol || !is_digit) begin
        acc_nxt    = '0;
        in_num_nxt = 1'b0;
        nerr_nxt   = iiee_pkg::ST_OK;
      end
    end
  end

  assign tok_valid = in_tvalid && emit;

  // Advance number state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      in_num_r <= 1'b0;
      nerr_r   <= iiee_pkg::ST_OK;
    end else if (in_tvalid && in_tready) begin
      acc_r    <= acc_nxt;
      in_num_r <= in_num_nxt;
      nerr_r   <= nerr_nxt;
    end
  end

endmodule

### hw/rtl/iiee_queue.sv
// ----------------------------------------------------------------------------
// iiee_queue
// Small token FIFO between front and back.
// ----------------------------------------------------------------------------
module iiee_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  iiee_pkg::tok_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output iiee_pkg::tok_t rd_data
);

  iiee_pkg::tok_t          mem_r [iiee_pkg::QDEPTH];
  logic [iiee_pkg::QAW-1:0] wp_r, rp_r;
  logic [iiee_pkg::QAW:0]   cnt_r;
  logic                     wr_en, rd_en;

  assign wr_ready = cnt_r != (iiee_pkg::QAW+1)'(iiee_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (iiee_pkg::QAW+1)'(wr_en) - (iiee_pkg::QAW+1)'(rd_en);
    end
  end

endmodule

### hw/rtl/iiee_back.sv
// ----------------------------------------------------------------------------
// iiee_back
// Applies tokens: running sum, running product term, iterative divider.
// ----------------------------------------------------------------------------
module iiee_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tok_valid,
  output logic                    tok_ready,
  input  iiee_pkg::tok_t          tok,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [iiee_pkg::VW+1:0] out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OP   = 2'd2;

  localparam int CW = $clog2(iiee_pkg::VW + 1);

  logic [1:0]              st_r, st_nxt;
  logic [iiee_pkg::VW-1:0] sum_r, sum_nxt, prod_r, prod_nxt;
  logic                    addop_r, addop_nxt;
  logic [1:0]              mop_r, mop_nxt;
  logic                    expn_r, expn_nxt;
  logic                    two_r, two_nxt;
  logic [1:0]              err_r, err_nxt;

  // Divider state
  logic [iiee_pkg::VW-1:0] dq_r, dq_nxt, drem_r, drem_nxt, dd_r, dd_nxt;
  logic [CW-1:0]           dcnt_r, dcnt_nxt;
  logic                    dneg_r, dneg_nxt, drm_r, drm_nxt;

  logic                    ov_r, ov_nxt;
  logic [iiee_pkg::VW+1:0] od_r, od_nxt;

  logic [iiee_pkg::VW:0]   trial;
  logic [iiee_pkg::VW-1:0] rsh;
  logic [iiee_pkg::VW-1:0] res_fin, mag_a, mag_b, qsel;
  logic [2*iiee_pkg::VW-1:0] mprod;
  logic                    acc_tok;

  assign tok_ready = (st_r == S_IDLE) && !ov_r;
  assign acc_tok   = tok_valid && tok_ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  assign mag_a = prod_r[iiee_pkg::VW-1] ? -prod_r : prod_r;
  assign mag_b = tok.num[iiee_pkg::VW-1] ? -tok.num : tok.num;
  assign mprod = prod_r * tok.num;
  assign rsh   = {drem_r[iiee_pkg::VW-2:0], dq_r[iiee_pkg::VW-1]};
  assign trial = {1'b0, rsh} - {1'b0, dd_r};
  assign qsel  = drm_r ? drem_r : dq_r;
  assign res_fin = dneg_r ? -qsel : qsel;

  always_comb begin
    st_nxt = st_r; sum_nxt = sum_r; prod_nxt = prod_r; addop_nxt = addop_r;
    mop_nxt = mop_r; expn_nxt = expn_r; two_nxt = two_r; err_nxt = err_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dd_nxt = dd_r; dcnt_nxt = dcnt_r;
    dneg_nxt = dneg_r; drm_nxt = drm_r;
    ov_nxt = ov_r && !out_tready; od_nxt = od_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc_tok) begin
          // Take the number part
          if (tok.has_num) begin
            err_nxt = iiee_pkg::err_merge(err_r, tok.num_err);
            if (!expn_r) err_nxt = iiee_pkg::err_merge(err_nxt, iiee_pkg::ST_INV);
            expn_nxt = 1'b0;
            mop_nxt  = iiee_pkg::MOP_NONE;
            priority if (mop_r == iiee_pkg::MOP_NONE) begin
              prod_nxt = tok.num;
            end else if (mop_r == iiee_pkg::MOP_MUL) begin
              prod_nxt = mprod[iiee_pkg::VW-1:0];
            end else if (tok.num == '0) begin
              err_nxt  = iiee_pkg::err_merge(err_nxt, iiee_pkg::ST_DIV0);
              prod_nxt = '0;
            end else begin
              dq_nxt   = mag_a;
              drem_nxt = '0;
              dd_nxt   = mag_b;
              dcnt_nxt = CW'(iiee_pkg::VW);
              drm_nxt  = (mop_r == iiee_pkg::MOP_REM);
              dneg_nxt = (mop_r == iiee_pkg::MOP_REM) ? prod_r[iiee_pkg::VW-1]
                       : (prod_r[iiee_pkg::VW-1] ^ tok.num[iiee_pkg::VW-1]);
              st_nxt   = S_DIV;
            end
          end else if (tok.num_err != iiee_pkg::ST_OK) begin
            err_nxt = iiee_pkg::err_merge(err_r, tok.num_err);
          end
          if (st_nxt == S_IDLE && (tok.op != iiee_pkg::TK_NONE || tok.eol)) st_nxt = S_OP;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle, then sign the result into the product
        if (dcnt_r != '0) begin
          if (!trial[iiee_pkg::VW]) begin
            drem_nxt = trial[iiee_pkg::VW-1:0];
            dq_nxt   = {dq_r[iiee_pkg::VW-2:0], 1'b1};
          end else begin
            drem_nxt = rsh;
            dq_nxt   = {dq_r[iiee_pkg::VW-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
        end else begin
          prod_nxt = res_fin;
          st_nxt   = S_OP;
        end
      end
      default: begin
        // Apply operator and line end
        st_nxt = S_OP;
        if (!ov_r) begin
          st_nxt = S_IDLE;
          if (tok.op != iiee_pkg::TK_NONE) begin
            if (expn_r) err_nxt = iiee_pkg::err_merge(err_r, iiee_pkg::ST_INV);
            unique case (tok.op)
              iiee_pkg::TK_PLUS, iiee_pkg::TK_MINUS: begin
                sum_nxt   = addop_r ? sum_r - prod_r : sum_r + prod_r;
                addop_nxt = (tok.op == iiee_pkg::TK_MINUS);
                mop_nxt   = iiee_pkg::MOP_NONE;
              end
              iiee_pkg::TK_MUL: mop_nxt = iiee_pkg::MOP_MUL;
              iiee_pkg::TK_DIV: mop_nxt = iiee_pkg::MOP_DIV;
              default:          mop_nxt = iiee_pkg::MOP_REM;
            endcase
            expn_nxt = 1'b1;
            two_nxt  = 1'b1;
          end
          if (tok.eol) begin
            if (expn_nxt || !two_nxt) err_nxt = iiee_pkg::err_merge(err_nxt, iiee_pkg::ST_INV);
            od_nxt = {err_nxt, (err_nxt == iiee_pkg::ST_OK) ?
                      (addop_nxt ? sum_nxt - prod_nxt : sum_nxt + prod_nxt) : {iiee_pkg::VW{1'b0}}};
            ov_nxt = 1'b1;
            sum_nxt = '0; prod_nxt = '0; addop_nxt = 1'b0; mop_nxt = iiee_pkg::MOP_NONE;
            expn_nxt = 1'b1; two_nxt = 1'b0; err_nxt = iiee_pkg::ST_OK;
          end
        end
      end
    endcase
  end

  // Hold the token under work: front token stays in queue head while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sum_r <= '0; prod_r <= '0; addop_r <= 1'b0;
      mop_r <= iiee_pkg::MOP_NONE; expn_r <= 1'b1; two_r <= 1'b0;
      err_r <= iiee_pkg::ST_OK; dcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sum_r <= sum_nxt; prod_r <= prod_nxt; addop_r <= addop_nxt;
      mop_r <= mop_nxt; expn_r <= expn_nxt; two_r <= two_nxt; err_r <= err_nxt;
      dcnt_r <= dcnt_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r <= dq_nxt; drem_r <= drem_nxt; dd_r <= dd_nxt;
    dneg_r <= dneg_nxt; drm_r <= drm_nxt; od_r <= od_nxt;
  end

endmodule

### sim/infix_integer_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator_tb
// Streams equation lines into the evaluator with random gaps and output
// stalls, predicts each line's value and status, and checks every result beat.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } line_result_t;

  char_beat_t   pending_chars[$];
  line_result_t expected_results[$];
  int           error_count;
  bit           quiet_mode;
  bit           hold_off_req;
  int           in_gap;
  int           out_gap;
  int           hold_cnt;

  // Predictor state for the line being fed
  logic [31:0] prev_answer;
  logic [31:0] acc;
  bit          in_num;
  logic [31:0] sum_val;
  logic [31:0] prod_val;
  logic        add_op;
  logic [1:0]  mul_op;
  bit          want_num;
  bit          seen_op;
  logic [1:0]  err;

  infix_integer_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void raise_error(input logic [1:0] code);
    if (code == iiee_pkg::ST_INV) err = iiee_pkg::ST_INV;
    else if (err == iiee_pkg::ST_OK) err = code;
  endfunction

  function automatic void clear_line_state();
    acc = '0; in_num = 0; sum_val = '0; prod_val = '0;
    add_op = 1'b0; mul_op = iiee_pkg::MOP_NONE; want_num = 1; seen_op = 0;
    err = iiee_pkg::ST_OK;
  endfunction

  function automatic logic [31:0] combine_product(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [1:0] op);
    logic signed [31:0] sa, sb;
    logic [31:0] ma, mb, r;
    sa = a; sb = b;
    if (op == iiee_pkg::MOP_MUL) return a * b;
    if (b == 0) begin
      raise_error(iiee_pkg::ST_DIV0);
      return '0;
    end
    ma = sa[31] ? -a : a;
    mb = sb[31] ? -b : b;
    if (op == iiee_pkg::MOP_DIV) begin
      r = ma / mb;
      return (sa[31] != sb[31]) ? -r : r;
    end
    r = ma % mb;
    return sa[31] ? -r : r;
  endfunction

  function automatic void take_number(input logic [31:0] v);
    if (!want_num) raise_error(iiee_pkg::ST_INV);
    if (mul_op == iiee_pkg::MOP_NONE) prod_val = v;
    else prod_val = combine_product(prod_val, v, mul_op);
    mul_op = iiee_pkg::MOP_NONE;
    want_num = 0;
  endfunction

  function automatic void close_number();
    if (in_num) take_number(acc);
    in_num = 0;
    acc = '0;
  endfunction

  // Advance the predictor by one character; queue a result on end of line
  function automatic void predict_char(input logic [7:0] c, input logic eol);
    logic [31:0]  d;
    logic [31:0]  v;
    line_result_t r;
    if (c >= iiee_pkg::CH_ZERO && c <= iiee_pkg::CH_NINE) begin
      d = {24'd0, c - iiee_pkg::CH_ZERO};
      in_num = 1;
      if (acc > (iiee_pkg::VMAX - d) / 32'd10) begin
        raise_error(iiee_pkg::ST_OVF);
        acc = iiee_pkg::VMAX;
      end else begin
        acc = acc * 32'd10 + d;
      end
    end else begin
      close_number();
      if (c == iiee_pkg::CH_A) begin
        v = prev_answer;
        if (v[31]) begin
          raise_error(iiee_pkg::ST_INV);
          v = '0;
        end
        take_number(v);
      end else if (c == iiee_pkg::CH_PLUS || c == iiee_pkg::CH_MINUS ||
                   c == iiee_pkg::CH_MUL || c == iiee_pkg::CH_DIV ||
                   c == iiee_pkg::CH_REM) begin
        if (want_num) raise_error(iiee_pkg::ST_INV);
        if (c == iiee_pkg::CH_PLUS || c == iiee_pkg::CH_MINUS) begin
          sum_val = add_op ? sum_val - prod_val : sum_val + prod_val;
          add_op = (c == iiee_pkg::CH_MINUS);
          mul_op = iiee_pkg::MOP_NONE;
        end else if (c == iiee_pkg::CH_MUL) begin
          mul_op = iiee_pkg::MOP_MUL;
        end else if (c == iiee_pkg::CH_DIV) begin
          mul_op = iiee_pkg::MOP_DIV;
        end else begin
          mul_op = iiee_pkg::MOP_REM;
        end
        want_num = 1;
        seen_op = 1;
      end
    end
    if (eol) begin
      close_number();
      if (want_num || !seen_op) raise_error(iiee_pkg::ST_INV);
      v = add_op ? sum_val - prod_val : sum_val + prod_val;
      r.value = (err == iiee_pkg::ST_OK) ? v : '0;
      r.status = err;
      expected_results.insert(expected_results.size(), r);
      clear_line_state();
    end
  endfunction

  // Drive: hold the beat until accepted, insert random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_chars[0].ch;
        in_tlast <= pending_chars[0].eol;
        void'(pending_chars.pop_front());
        if (!quiet_mode && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        if (out_tdata[31:0] !== expected_results[0].value)
          report_mismatch($sformatf("value got %0d want %0d", $signed(out_tdata[31:0]),
                                    $signed(expected_results[0].value)));
        if (out_tdata[33:32] !== expected_results[0].status)
          report_mismatch($sformatf("status got %0d want %0d", out_tdata[33:32],
                                    expected_results[0].status));
        void'(expected_results.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
    end else if (hold_off_req && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void queue_char(input logic [7:0] ch, input logic eol);
    char_beat_t b;
    b.ch = ch;
    b.eol = eol;
    pending_chars.insert(pending_chars.size(), b);
  endfunction

  function automatic void push_line(input string s);
    for (int i = 0; i < s.len(); i++)
      queue_char(s[i], (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] random_digit();
    return iiee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Build one random line, mostly well formed with random content
  function automatic void push_random_line();
    logic [7:0] ops[5];
    int ntok;
    int len;
    logic [7:0] c;
    ops = '{iiee_pkg::CH_PLUS, iiee_pkg::CH_MINUS, iiee_pkg::CH_MUL, iiee_pkg::CH_DIV,
            iiee_pkg::CH_REM};
    if ($urandom_range(0, 9) == 0) begin
      // noise: any byte values at all
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        queue_char(8'($urandom_range(0, 255)), (i == len - 1));
      return;
    end
    ntok = 2 * $urandom_range(1, 4) + 1;
    if ($urandom_range(0, 9) == 0) ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      if (t % 2 == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_char(iiee_pkg::CH_A, 1'b0);
        end else begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
          for (int i = 0; i < len; i++)
            queue_char(random_digit(), 1'b0);
        end
      end else begin
        queue_char(ops[$urandom_range(0, 4)], 1'b0);
      end
      if ($urandom_range(0, 4) == 0) queue_char(8'h20, 1'b0);
    end
    c = ($urandom_range(0, 1) == 0) ? 8'h0A : 8'h20;
    queue_char(c, 1'b1);
  endfunction

  task automatic wait_drained();
    while (pending_chars.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_answer(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    prev_answer = v;
  endtask

  initial begin
    logic [31:0] answers[6];
    answers = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd7, 32'd1};
    error_count = 0;
    quiet_mode = 0;
    hold_off_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    prev_answer = '0;
    clear_line_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: precedence, every operator, error cases and edge values
    push_line("2+3*4-10/3%2");
    push_line("2147483647+1");
    push_line("99999999999*1");
    push_line("7/0+1");
    push_line("5%0*99999999999");
    push_line("0-2147483647-1");
    push_line("a5+1\n");
    push_line("3++4");
    push_line("a+a");
    push_line("-5");
    push_line("a");
    wait_drained();
    write_answer(32'h80000000);
    push_line("a+1");
    wait_drained();

    // Wrapped negative products as dividends, and the most negative sum
    write_answer(32'h7FFFFFFF);
    push_line("0-a-1+0*1 ");
    push_line("a*2/2%7");
    push_line("65536*32768/3");
    push_line("65536*32768%7");
    wait_drained();

    // Random phases across several previous answers; long hold-off in one
    for (int p = 0; p < 6; p++) begin
      write_answer(p == 5 ? $urandom() : answers[p]);
      if (p == 2) hold_off_req = 1;
      if (p == 5) quiet_mode = 1;
      for (int n = 0; n < 22; n++) push_random_line();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
